>>> hw/rtl/ps2mt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ps2mt_pkg
// Shared types, constants and the coordinate clamp for the PS/2 cursor tracker.
// ---------------------------------------------------------------------------
package ps2mt_pkg;

    localparam int COORD_BITS = 12;
    localparam int LIMIT_BITS = 12;
    localparam int OUT_BITS   = 12;
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;
    localparam int DELTA_BITS = 9;

    localparam int WIDE_BITS  = (COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS;
    localparam int CALC_W     = WIDE_BITS + 2;

    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int RESET_X    = (512 > COORD_MAX) ? COORD_MAX : 512;
    localparam int RESET_Y    = (384 > COORD_MAX) ? COORD_MAX : 384;

    localparam logic [LIMIT_BITS-1:0] HLIMIT_RESET = LIMIT_BITS'(1024);
    localparam logic [LIMIT_BITS-1:0] VLIMIT_RESET = LIMIT_BITS'(768);

    // register index taken from paddr[2]
    localparam logic REG_HLIMIT = 1'b0;
    localparam logic REG_VLIMIT = 1'b1;

    // status byte bit positions
    localparam int SIGN_X_POS = 4;
    localparam int SIGN_Y_POS = 5;
    localparam int OVF_X_POS  = 6;
    localparam int OVF_Y_POS  = 7;

    typedef enum logic [3:0] {
        PH_STATUS = 4'b0001,
        PH_DX     = 4'b0010,
        PH_DY     = 4'b0100,
        PH_SKIP   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] hlimit;
        logic [LIMIT_BITS-1:0] vlimit;
    } limits_t;

    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [CALC_W-1:0] v,
        input logic [LIMIT_BITS-1:0]    limit
    );
        logic signed [CALC_W-1:0] lim;
        logic signed [CALC_W-1:0] res;
        lim = $signed(CALC_W'(limit));
        if (lim > $signed(CALC_W'(COORD_MAX)))
        begin
            lim = $signed(CALC_W'(COORD_MAX));
        end
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > lim)
        begin
            res = lim;
        end
        else
        begin
            res = v;
        end
        return res[COORD_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ps2mt_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ps2mt_apb_regs
// APB register file holding the horizontal and vertical cursor limits.
// ---------------------------------------------------------------------------
module ps2mt_apb_regs
    import ps2mt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready,
    output limits_t                   limits
);

    logic [LIMIT_BITS-1:0] hlimit_reg;
    logic [LIMIT_BITS-1:0] vlimit_reg;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hlimit_reg <= HLIMIT_RESET;
            vlimit_reg <= VLIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_HLIMIT: hlimit_reg <= pwdata[LIMIT_BITS-1:0];
                REG_VLIMIT: vlimit_reg <= pwdata[LIMIT_BITS-1:0];
                default:    hlimit_reg <= hlimit_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_HLIMIT: prdata = DATA_BITS'(hlimit_reg);
            REG_VLIMIT: prdata = DATA_BITS'(vlimit_reg);
            default:    prdata = '0;
        endcase
    end

    assign limits.hlimit = hlimit_reg;
    assign limits.vlimit = vlimit_reg;

endmodule
`default_nettype wire

>>> hw/rtl/ps2_mouse_packet_cursor_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_unit
// Groups PS/2 mouse bytes into three-byte packets and tracks a clamped cursor.
// ---------------------------------------------------------------------------
// A result word passes the input register and is then written to the result word register with the new cursor.
// Throughput: one byte per cycle unless out_stall holds a pending result; set
// by the input register and the single update stage holding phase and cursor.
// Reset: phase discards the first byte, cursor at 512/384, limits 1024/768,
// no word pending on either side.
module ps2_mouse_packet_cursor_tracker_unit
    import ps2mt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           rx_byte,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [OUT_BITS-1:0]  cursor_x,
    output logic      [OUT_BITS-1:0]  cursor_y,
    output logic      [7:0]           status_bits
);

    limits_t limits;

    ps2mt_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limits  (limits)
    );

    logic                         in_valid_reg;
    logic [7:0]                   in_byte_reg;
    phase_t                       phase_reg, phase_next;
    logic [7:0]                   status_reg, status_next;
    logic signed [DELTA_BITS-1:0] dx_reg, dx_next;
    logic [COORD_BITS-1:0]        pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0]        pos_y_reg, pos_y_next;
    logic                         out_valid_reg;
    logic [OUT_BITS-1:0]          out_x_reg;
    logic [OUT_BITS-1:0]          out_y_reg;
    logic [7:0]                   out_status_reg;

    logic                         fire;
    logic                         produce;
    logic                         in_accept;
    logic signed [DELTA_BITS-1:0] dy;
    logic signed [CALC_W-1:0]     sum_x;
    logic signed [CALC_W-1:0]     diff_y;
    logic [CALC_W-1:0]            wide_x;
    logic [CALC_W-1:0]            wide_y;

    assign fire      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // packet update
    always_comb
    begin
        phase_next  = phase_reg;
        status_next = status_reg;
        dx_next     = dx_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        produce     = 1'b0;
        dy          = $signed({status_reg[SIGN_Y_POS], in_byte_reg});
        sum_x       = $signed(CALC_W'(pos_x_reg)) + CALC_W'(dx_reg);
        diff_y      = $signed(CALC_W'(pos_y_reg)) - CALC_W'(dy);
        if (fire)
        begin
            unique case (phase_reg)
                PH_STATUS:
                begin
                    status_next = in_byte_reg;
                    phase_next  = PH_DX;
                end
                PH_DX:
                begin
                    dx_next    = $signed({status_reg[SIGN_X_POS], in_byte_reg});
                    phase_next = PH_DY;
                end
                PH_DY:
                begin
                    phase_next = PH_STATUS;
                    if (!status_reg[OVF_X_POS] && !status_reg[OVF_Y_POS])
                    begin
                        pos_x_next = clamp_coord(sum_x, limits.hlimit);
                        pos_y_next = clamp_coord(diff_y, limits.vlimit);
                        produce    = 1'b1;
                    end
                end
                PH_SKIP:
                begin
                    phase_next = PH_STATUS;
                end
                default:
                begin
                    phase_next = PH_STATUS;
                end
            endcase
        end
    end

    assign wide_x = CALC_W'(pos_x_next);
    assign wide_y = CALC_W'(pos_y_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SKIP;
            status_reg <= '0;
            dx_reg     <= '0;
            pos_x_reg  <= COORD_BITS'(RESET_X);
            pos_y_reg  <= COORD_BITS'(RESET_Y);
        end
        else
        begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            dx_reg     <= dx_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= produce;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && produce)
        begin
            out_x_reg      <= wide_x[OUT_BITS-1:0];
            out_y_reg      <= wide_y[OUT_BITS-1:0];
            out_status_reg <= status_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cursor_x    = out_x_reg;
    assign cursor_y    = out_y_reg;
    assign status_bits = out_status_reg;

    a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stall without a held word");

    a_result_from_dy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fire && phase_reg == PH_DY))
        else $error("result word not caused by a Y delta byte");

    a_ovf_keeps_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == PH_DY && (status_reg[OVF_X_POS] || status_reg[OVF_Y_POS]))
        |=> ($stable(pos_x_reg) && $stable(pos_y_reg) && !$rose(out_valid_reg)))
        else $error("overflow packet moved the cursor");

    a_cursor_moves_on_dy: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && phase_reg == PH_DY) |=> ($stable(pos_x_reg) && $stable(pos_y_reg)))
        else $error("cursor changed outside a packet end");

endmodule
`default_nettype wire
